// File: rtl/core/scpf_pkg.sv
`default_nettype none
package scpf_pkg;

    // Frame constants
    localparam logic [7:0] START_BYTE  = 8'hFE;
    localparam logic [7:0] PAYLOAD_LEN = 8'd33;
    localparam logic [7:0] MSG_ID      = 8'd76;
    localparam logic [7:0] CMD_LO      = 8'd183;
    localparam logic [7:0] CRC_SUFFIX  = 8'd152;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Configuration register indexes
    localparam logic [7:0] CFG_SRC_SYS  = 8'd0;
    localparam logic [7:0] CFG_SRC_COMP = 8'd1;
    localparam logic [7:0] CFG_TGT_SYS  = 8'd2;
    localparam logic [7:0] CFG_TGT_COMP = 8'd3;

    // Control of the checksum unit
    typedef struct packed {
        logic clear;   // restart at the seed
        logic step;    // fold i_byte in
        logic extra;   // fold the suffix byte in after i_byte
    } t_crc_ctl;

endpackage
`default_nettype wire

// File: rtl/core/scpf_ram.sv
`default_nettype none
module scpf_ram #(
    parameter int W = 16,
    parameter int D = 256
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire [W-1:0]                 i_wdata,
    input  wire                         i_re,
    input  wire [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                o_rdata
);

    logic [W-1:0] r_mem [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/scpf_norm.sv
`default_nettype none
// Serial integer to single conversion: shift left one bit a cycle until
// the leading one reaches the top, counting the shifts.
module scpf_norm #(
    parameter int W = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_load,
    input  wire [W-1:0]  i_value,
    output logic         o_done,
    output logic [31:0]  o_single
);

    localparam int SW = (W > 1) ? $clog2(W) : 1;
    localparam logic [7:0] ExpTop = 8'(127 + W - 1);

    logic [W-1:0]  r_val;
    logic [SW-1:0] r_shift;
    logic          w_zero;
    logic [7:0]    w_exp;
    logic [22:0]   w_mant;

    assign w_zero = (r_val == '0);
    assign o_done = w_zero || r_val[W-1];
    assign w_exp  = ExpTop - 8'(r_shift);
    assign w_mant = 23'({r_val[W-2:0], {(24 - W){1'b0}}});
    assign o_single = w_zero ? 32'd0 : {1'b0, w_exp, w_mant};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val   <= '0;
            r_shift <= '0;
        end else if (i_load) begin
            r_val   <= i_value;
            r_shift <= '0;
        end else if (!o_done) begin
            r_val   <= {r_val[W-2:0], 1'b0};
            r_shift <= r_shift + SW'(1);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/scpf_crc.sv
`default_nettype none
// CRC-16/MCRF4XX, one byte a cycle, with an optional second byte folded in.
module scpf_crc (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  scpf_pkg::t_crc_ctl   i_ctl,
    input  wire [7:0]            i_byte,
    output logic [15:0]          o_crc
);

    import scpf_pkg::*;

    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] c);
        logic [7:0] t;
        begin
            t = b ^ c[7:0];
            t = t ^ {t[3:0], 4'b0};
            crc_step = {8'b0, c[15:8]} ^ {t, 8'b0} ^ {5'b0, t, 3'b0} ^ {12'b0, t[7:4]};
        end
    endfunction

    logic [15:0] w_one;
    logic [15:0] w_two;

    assign w_one = crc_step(i_byte, o_crc);
    assign w_two = crc_step(CRC_SUFFIX, w_one);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_crc <= CRC_INIT;
        end else if (i_ctl.clear) begin
            o_crc <= CRC_INIT;
        end else if (i_ctl.step) begin
            o_crc <= i_ctl.extra ? w_two : w_one;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/servo_command_packet_framer_top.sv
`default_nettype none
// Channel  | Direction | Handshake                | Content
// s_*      | in        | i_s_tvalid / o_s_tready  | tdata: channel, pulse_width
// m_*      | out       | o_m_tvalid / i_m_tready  | tdata: frame_byte; tlast: frame_end
// cfg_*    | in        | i_cfg_valid / o_cfg_ready| register index, 8-bit value
//
// A request is taken in idle. The lookup state compares it with the last
// pulse width sent on that channel in the store RAM; a repeat returns to idle
// with no output. A new value streams 41 bytes, one a cycle while the sink
// takes them, through the output register; the serial normaliser of a small
// pulse width may still be shifting as byte 6 comes due, holding it back.
// Reset clears the valid bit of every channel at once; no clearing pass.
// Output stalls hold the byte sequencer; a new request may be taken while the
// final byte of the previous frame still waits in the output register.
module servo_command_packet_framer_top #(
    parameter int CHANNELS = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request in
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [23:0]  i_s_tdata,    // [7:0] channel, [23:8] pulse_width
    // frame bytes out
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,    // [7:0] frame_byte
    output logic        o_m_tlast,    // frame_end
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [7:0]   i_cfg_index,
    input  wire [7:0]   i_cfg_data
);

    import scpf_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [8:0] ChanLimit = 9'(CHANNELS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    // Byte positions in the frame
    localparam logic [5:0] IDX_START  = 6'd0;
    localparam logic [5:0] IDX_LEN    = 6'd1;
    localparam logic [5:0] IDX_SEQ    = 6'd2;
    localparam logic [5:0] IDX_SRCS   = 6'd3;
    localparam logic [5:0] IDX_SRCC   = 6'd4;
    localparam logic [5:0] IDX_MSG    = 6'd5;
    localparam logic [5:0] IDX_PAR    = 6'd6;
    localparam logic [5:0] IDX_PAREND = 6'd13;
    localparam logic [5:0] IDX_CMD    = 6'd34;
    localparam logic [5:0] IDX_TGTS   = 6'd36;
    localparam logic [5:0] IDX_TGTC   = 6'd37;
    localparam logic [5:0] IDX_CONF   = 6'd38;
    localparam logic [5:0] IDX_CRCLO  = 6'd39;
    localparam logic [5:0] IDX_CRCHI  = 6'd40;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_idx, n_idx;
    logic [7:0]  r_seq;
    logic [7:0]  r_ch;
    logic [15:0] r_pw;
    logic [55:0] r_par;
    logic [7:0]  r_src_sys, r_src_comp, r_tgt_sys, r_tgt_comp;
    logic [CHANNELS-1:0] r_valid;
    logic        r_m_valid;
    logic [7:0]  r_m_byte;
    logic        r_m_last;

    logic        w_accept;
    logic        w_stored;
    logic        w_repeat;
    logic        w_send_start;
    logic [15:0] w_last_pw;
    logic        w_ch_done, w_pw_done;
    logic [31:0] w_ch_single, w_pw_single;
    logic [63:0] w_pair;
    logic        w_free;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic [15:0] w_crc;
    t_crc_ctl    w_crc_ctl;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_byte;
    assign o_m_tlast   = r_m_last;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_stored = ({1'b0, r_ch} < ChanLimit);
    assign w_repeat = w_stored && r_valid[r_ch[AW-1:0]] && (w_last_pw == r_pw);
    assign w_send_start = (r_state == S_LOOK) && !w_repeat;

    // Last pulse width sent per channel; read on the accept edge
    scpf_ram #(
        .W (16),
        .D (CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_send_start && w_stored),
        .i_waddr (r_ch[AW-1:0]),
        .i_wdata (r_pw),
        .i_re    (w_accept),
        .i_raddr (i_s_tdata[AW-1:0]),
        .o_rdata (w_last_pw)
    );

    scpf_norm #(.W(8)) u_norm_ch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_value  (i_s_tdata[7:0]),
        .o_done   (w_ch_done),
        .o_single (w_ch_single)
    );

    scpf_norm #(.W(16)) u_norm_pw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_value  (i_s_tdata[23:8]),
        .o_done   (w_pw_done),
        .o_single (w_pw_single)
    );

    assign w_pair = {w_pw_single, w_ch_single};

    // Advance one byte when the output register is free; hold at the first
    // parameter byte until both conversions have settled
    assign w_free = !r_m_valid || i_m_tready;
    assign w_emit = (r_state == S_SEND) && w_free
                    && ((r_idx != IDX_PAR) || (w_ch_done && w_pw_done));

    always_comb begin
        w_byte = 8'd0;
        if (r_idx == IDX_PAR) begin
            w_byte = w_pair[7:0];
        end else if ((r_idx > IDX_PAR) && (r_idx <= IDX_PAREND)) begin
            w_byte = r_par[7:0];
        end else begin
            case (r_idx)
                IDX_START: w_byte = START_BYTE;
                IDX_LEN:   w_byte = PAYLOAD_LEN;
                IDX_SEQ:   w_byte = r_seq;
                IDX_SRCS:  w_byte = r_src_sys;
                IDX_SRCC:  w_byte = r_src_comp;
                IDX_MSG:   w_byte = MSG_ID;
                IDX_CMD:   w_byte = CMD_LO;
                IDX_TGTS:  w_byte = r_tgt_sys;
                IDX_TGTC:  w_byte = r_tgt_comp;
                IDX_CRCLO: w_byte = w_crc[7:0];
                IDX_CRCHI: w_byte = w_crc[15:8];
                default:   w_byte = 8'd0;
            endcase
        end
    end

    // Checksum covers the length byte through the confirmation byte, then
    // the extra byte in the same cycle as the confirmation byte
    always_comb begin
        w_crc_ctl.clear = w_send_start;
        w_crc_ctl.step  = w_emit && (r_idx >= IDX_LEN) && (r_idx <= IDX_CONF);
        w_crc_ctl.extra = (r_idx == IDX_CONF);
    end

    scpf_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_byte  (w_byte),
        .o_crc   (w_crc)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_idx   = IDX_START;
                n_state = w_repeat ? S_IDLE : S_SEND;
            end
            S_SEND: begin
                if (w_emit) begin
                    n_idx = r_idx + 6'd1;
                    if (r_idx == IDX_CRCHI) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= IDX_START;
            r_seq      <= 8'd0;
            r_valid    <= '0;
            r_m_valid  <= 1'b0;
            r_src_sys  <= 8'd255;
            r_src_comp <= 8'd0;
            r_tgt_sys  <= 8'd1;
            r_tgt_comp <= 8'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SRC_SYS:  r_src_sys  <= i_cfg_data;
                    CFG_SRC_COMP: r_src_comp <= i_cfg_data;
                    CFG_TGT_SYS:  r_tgt_sys  <= i_cfg_data;
                    CFG_TGT_COMP: r_tgt_comp <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_send_start && w_stored) begin
                r_valid[r_ch[AW-1:0]] <= 1'b1;
            end
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_emit && (r_idx == IDX_CRCHI)) begin
                r_seq <= r_seq + 8'd1;
            end
        end
    end

    // Payload and output byte registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch <= i_s_tdata[7:0];
            r_pw <= i_s_tdata[23:8];
        end
        if (w_emit) begin
            r_m_byte <= w_byte;
            r_m_last <= (r_idx == IDX_CRCHI);
            if (r_idx == IDX_PAR) begin
                r_par <= w_pair[63:8];
            end else begin
                r_par <= {8'd0, r_par[55:8]};
            end
        end
    end

    a_look_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state != S_LOOK))
        else $error("store lookup lasted more than one cycle");

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_idx == IDX_CRCHI)) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the last byte");

    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_idx == IDX_CRCHI)) |=> (r_seq == 8'($past(r_seq) + 8'd1)))
        else $error("sequence number did not advance at frame end");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_idx <= IDX_CRCHI))
        else $error("byte index ran past the frame");

    a_par_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_idx == IDX_PAR)) |-> (w_ch_done && w_pw_done))
        else $error("parameter bytes left before conversion settled");

endmodule
`default_nettype wire
